// File: hdl/assert_macros.svh
// Assertion macros shared by the sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define CLBS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define CLBS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/clbs_pkg.sv
// Types, codes and fixed tables of the character LCD bus sequencer.
package clbs_pkg;

  localparam logic [1:0] REQ_CMD    = 2'd0;
  localparam logic [1:0] REQ_DATA   = 2'd1;
  localparam logic [1:0] REQ_INIT   = 2'd2;
  localparam logic [1:0] REQ_CURSOR = 2'd3;

  localparam logic [6:0] INIT_HOLD_MS = 7'd100;
  localparam logic [2:0] PAUSE_SHORT  = 3'd1;
  localparam logic [2:0] PAUSE_LONG   = 3'd4;

  typedef enum logic [1:0] {
    KIND_PAUSE = 2'd0,
    KIND_CMD   = 2'd1,
    KIND_DATA  = 2'd2
  } step_kind_t;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic       load_req;
    logic       load_list;
    logic [2:0] list_idx;
    logic       latch_mode;
    logic       emit;
    step_kind_t kind;
    logic [2:0] step;
    logic [2:0] extra;
    logic       last;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic four_bit;
  } dp_status_t;

  // Index of the final pin step of one byte transfer.
  function automatic logic [2:0] step_last(step_kind_t kind, logic four);
    logic [2:0] r;
    r = 3'd0;
    if (kind == KIND_CMD) begin
      r = four ? 3'd4 : 3'd2;
    end else if (kind == KIND_DATA) begin
      r = four ? 3'd3 : 3'd1;
    end
    return r;
  endfunction

  // Index of the final command of the init list.
  function automatic logic [2:0] list_last(logic four);
    return four ? 3'd4 : 3'd3;
  endfunction

  function automatic logic [7:0] list_byte(logic four, logic [2:0] idx);
    logic [7:0] b;
    b = 8'h00;
    if (four) begin
      unique case (idx)
        3'd0:    b = 8'h02;
        3'd1:    b = 8'h28;
        3'd2:    b = 8'h01;
        3'd3:    b = 8'h0C;
        3'd4:    b = 8'h06;
        default: b = 8'h00;
      endcase
    end else begin
      unique case (idx)
        3'd0:    b = 8'h38;
        3'd1:    b = 8'h01;
        3'd2:    b = 8'h0E;
        3'd3:    b = 8'h80;
        default: b = 8'h00;
      endcase
    end
    return b;
  endfunction

  function automatic logic [7:0] row_base(logic [1:0] row);
    logic [7:0] b;
    unique case (row)
      2'd0:    b = 8'h80;
      2'd1:    b = 8'hC0;
      2'd2:    b = 8'h94;
      default: b = 8'hD4;
    endcase
    return b;
  endfunction

endpackage

// File: hdl/clbs_req_if.sv
// Request channel: one request per transaction.
interface clbs_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] value;
  logic [1:0] row;
  logic [5:0] column;

  modport source (output valid, output req_type, output value, output row, output column,
                  input ready);
  modport sink (input valid, input req_type, input value, input row, input column,
                output ready);
endinterface

// File: hdl/clbs_step_if.sv
// Pin step channel: one bus step per transaction.
interface clbs_step_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_pins;
  logic       reg_select;
  logic       read_write;
  logic       enable;
  logic [6:0] hold_ms;
  logic       last;

  modport source (output valid, output data_pins, output reg_select, output read_write,
                  output enable, output hold_ms, output last, input ready);
  modport sink (input valid, input data_pins, input reg_select, input read_write,
                input enable, input hold_ms, input last, output ready);
endinterface

// File: hdl/clbs_cfg_if.sv
// Configuration write channel for the init_mode register.
interface clbs_cfg_if;
  logic valid;
  logic ready;
  logic init_mode;

  modport source (output valid, output init_mode, input ready);
  modport sink (input valid, input init_mode, output ready);
endinterface

// File: hdl/clbs_ctrl.sv
// Controller state machine that sequences the pin steps of each request.
module clbs_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  logic [1:0]            req_type,
  input  clbs_pkg::dp_status_t  status,
  output clbs_pkg::ctrl_cmd_t   cmd
);
  import clbs_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PAUSE = 4'b0010,
    ST_CMD   = 4'b0100,
    ST_DATA  = 4'b1000
  } state_t;

  state_t     state, state_next;
  logic [2:0] step, step_next;
  logic [2:0] list_idx, list_idx_next;
  logic       init_run, init_run_next;

  logic       final_step;
  logic       list_done;

  assign req_ready  = (state == ST_IDLE);
  assign final_step = (step == step_last((state == ST_DATA) ? KIND_DATA : KIND_CMD,
                                         status.four_bit));
  assign list_done  = !init_run || (list_idx == list_last(status.four_bit));

  always_comb begin
    state_next    = state;
    step_next     = step;
    list_idx_next = list_idx;
    init_run_next = init_run;
    cmd           = '0;
    cmd.kind      = KIND_PAUSE;
    cmd.step      = step;
    cmd.list_idx  = list_idx;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          step_next     = 3'd0;
          list_idx_next = 3'd0;
          init_run_next = 1'b0;
          cmd.load_req  = 1'b1;
          priority case (req_type)
            REQ_DATA: state_next = ST_DATA;
            REQ_INIT: begin
              state_next    = ST_PAUSE;
              init_run_next = 1'b1;
            end
            default:  state_next = ST_CMD;
          endcase
        end
      end
      ST_PAUSE: begin
        cmd.kind = KIND_PAUSE;
        if (status.out_free) begin
          cmd.emit       = 1'b1;
          cmd.latch_mode = 1'b1;
          cmd.load_list  = 1'b1;
          cmd.list_idx   = 3'd0;
          step_next      = 3'd0;
          state_next     = ST_CMD;
        end
      end
      ST_CMD, ST_DATA: begin
        cmd.kind = (state == ST_DATA) ? KIND_DATA : KIND_CMD;
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (final_step) begin
            // The pause after each init command adds to its final step.
            if (init_run) begin
              cmd.extra = (list_idx == 3'd0 && status.four_bit) ? PAUSE_LONG : PAUSE_SHORT;
            end
            cmd.last  = list_done;
            step_next = 3'd0;
            if (list_done) begin
              state_next = ST_IDLE;
            end else begin
              list_idx_next = list_idx + 3'd1;
              cmd.load_list = 1'b1;
              cmd.list_idx  = list_idx + 3'd1;
            end
          end else begin
            step_next = step + 3'd1;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step     <= 3'd0;
      list_idx <= 3'd0;
      init_run <= 1'b0;
    end else begin
      state    <= state_next;
      step     <= step_next;
      list_idx <= list_idx_next;
      init_run <= init_run_next;
    end
  end

endmodule

// File: hdl/clbs_dp.sv
// Datapath: bus latches, byte register, step formatting and the output register.
module clbs_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [1:0]           req_type,
  input  logic [7:0]           value,
  input  logic [1:0]           row,
  input  logic [5:0]           column,
  input  clbs_pkg::ctrl_cmd_t  cmd,
  output clbs_pkg::dp_status_t status,
  clbs_cfg_if.sink             cfg,
  clbs_step_if.source          step
);
  import clbs_pkg::*;

  logic       cfg_mode;
  logic       four_bit;
  logic [7:0] data_latch;
  logic       rs_latch;
  logic [7:0] byte_reg;
  logic       out_valid;

  logic [7:0] pins;
  logic       rs;
  logic       en;
  logic [6:0] hold;
  logic       low_half;

  assign cfg.ready       = 1'b1;
  assign status.four_bit = four_bit;
  assign status.out_free = !out_valid || step.ready;
  assign step.valid      = out_valid;
  assign step.read_write = 1'b0;

  always_comb begin
    pins     = byte_reg;
    rs       = rs_latch;
    en       = 1'b0;
    hold     = 7'd1;
    low_half = 1'b0;
    unique case (cmd.kind)
      KIND_CMD: begin
        rs       = (cmd.step == 3'd0) ? rs_latch : 1'b0;
        en       = (cmd.step == 3'd1) || (cmd.step == 3'd3);
        low_half = (cmd.step >= 3'd3);
        if (four_bit) begin
          hold = (cmd.step == 3'd2 || cmd.step == 3'd4) ? 7'd2 : 7'd1;
        end else begin
          hold = (cmd.step == 3'd2) ? 7'd0 : 7'd1;
        end
      end
      KIND_DATA: begin
        rs       = 1'b1;
        en       = !cmd.step[0];
        low_half = (cmd.step >= 3'd2);
        hold     = (four_bit && cmd.step == 3'd3) ? 7'd2 : 7'd1;
      end
      default: begin
        pins = data_latch;
        hold = INIT_HOLD_MS;
      end
    endcase
    if (cmd.kind != KIND_PAUSE && four_bit) begin
      pins = low_half ? {byte_reg[3:0], data_latch[3:0]} : {byte_reg[7:4], data_latch[3:0]};
    end
    hold = hold + {4'd0, cmd.extra};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_mode   <= 1'b0;
      four_bit   <= 1'b0;
      data_latch <= 8'h00;
      rs_latch   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg.valid) begin
        cfg_mode <= cfg.init_mode;
      end
      if (cmd.latch_mode) begin
        four_bit <= cfg_mode;
      end
      if (cmd.emit) begin
        data_latch <= pins;
        rs_latch   <= rs;
        out_valid  <= 1'b1;
      end else if (step.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      byte_reg <= (req_type == REQ_CURSOR) ? row_base(row) + {2'b00, column} : value;
    end else if (cmd.load_list) begin
      // The list follows the width being latched in the same cycle.
      byte_reg <= list_byte(cmd.latch_mode ? cfg_mode : four_bit, cmd.list_idx);
    end
    if (cmd.emit) begin
      step.data_pins  <= pins;
      step.reg_select <= rs;
      step.enable     <= en;
      step.hold_ms    <= hold;
      step.last       <= cmd.last;
    end
  end

endmodule

// File: hdl/char_lcd_bus_sequencer_core.sv
// Top level of the character LCD bus sequencer: controller, datapath and checks.
// Each request transaction becomes a run of pin step transactions for an
// HD44780-style display: a command byte gives 3 steps on the 8-bit bus or 5
// on the 4-bit bus, a data byte 2 or 4, a set-cursor request is sent as a
// command to the row base plus column (wrapping at 8 bits), and an init
// request gives a 100 ms hold step followed by the list for the configured
// width; the whole run is 13 steps in 8-bit mode and 26 in 4-bit mode. The last
// flag marks the final step of each run. A request is first accepted and
// captured, then its steps follow at one step per cycle while the sink takes
// every step at once, paced by the controller emitting into the single output
// register. A stalled sink stretches the run step by step. The next request is
// accepted as soon as the final step has been written into the output register,
// even if the sink has not taken it.
// The init_mode register is written over its own channel, which is always
// ready, and is sampled only when an init request latches the bus width.
// Requests sent before any init use the 8-bit bus.
`include "assert_macros.svh"

module char_lcd_bus_sequencer_core (
  input logic         clk,
  input logic         rst,
  clbs_req_if.sink    req,
  clbs_step_if.source step,
  clbs_cfg_if.sink    cfg
);
  import clbs_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // The controller owns the request handshake and the sequence position.
  clbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_type  (req.req_type),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath owns the bus latches, the byte being sent and the step output.
  clbs_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .req_type (req.req_type),
    .value    (req.value),
    .row      (req.row),
    .column   (req.column),
    .cmd      (cmd),
    .status   (status),
    .cfg      (cfg),
    .step     (step)
  );

  // A request transaction starts a run, so no second request is taken next cycle.
  `CLBS_ASSERT(a_one_request, clk, rst, (req.valid && req.ready) |=> !req.ready, "request accepted while busy")
  // After the final step of a run is issued, the controller is ready for a request.
  `CLBS_ASSERT(a_last_idle, clk, rst, (cmd.emit && cmd.last) |=> req.ready, "run did not end after last step")
  // A step is issued only when the output register can take it.
  `CLBS_ASSERT(a_emit_room, clk, rst, cmd.emit |-> status.out_free, "step issued into a full output register")

endmodule
